>>> rtl/stsmq_pkg.sv
// Shared types and constants for the segment tree sum/min query block.
`default_nettype none
package stsmq_pkg;

  localparam int SUM_W = 48;
  localparam int MIN_W = 32;

  localparam logic signed [MIN_W-1:0] EMPTY_MIN32 = 32'sd1000000007;
  localparam logic signed [SUM_W-1:0] EMPTY_MIN48 = 48'sd1000000007;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_ADD   = 3'd1,
    OP_PMIN  = 3'd2,
    OP_RSUM  = 3'd3,
    OP_RMIN  = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_DESC,
    ST_LEAF,
    ST_UP_RD,
    ST_UP_MRG,
    ST_VISIT,
    ST_FETCH,
    ST_RET
  } state_t;

  typedef struct packed {
    logic capture;
    logic clr_start;
    logic clr_step;
    logic desc_step;
    logic rd_cur;
    logic leaf_wr;
    logic sib_rd;
    logic merge_wr;
    logic push_left;
    logic push_right;
    logic ret_mem;
    logic ret_empty;
    logic turn;
    logic pop;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic leaf;
    logic at_root;
    logic parent_root;
    logic covered;
    logic go_left;
    logic sp_zero;
    logic turn_ok;
    logic range_empty;
    logic clr_last;
    logic out_free;
  } sts_t;

  // Adds two 48-bit signed values and saturates to the 48-bit signed range.
  function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUM_W-1:0] a,
                                                     input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat48 = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat48 = s[SUM_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/segment_tree_sum_min_query.sv
// Top level of the segment tree block with point updates and range sum/min queries.
// Requests arrive on req_valid/req_stall with operation, position, value, range_low
// and range_high; a request is taken at an edge where req_valid is high and
// req_stall low. Range sum and range min requests give one result on
// res_valid/res_stall (answer, none_found); clear and point updates give none.
// The leaf_count register is written on cfg_valid/cfg_ready with cfg_data.
// One request is worked at a time. A point update walks down the tree one level
// a cycle and back up through the single read port of the node stores, reading
// the sibling and then writing the merged parent at each level. A range query
// visits nodes on an explicit stack. A clear writes one node a cycle.
// After reset the block runs the same clearing pass and holds req_stall high
// until it is done; leaf_count resets to 1024.
// A finished result sits in an output register, so a stalled receiver only
// holds back the next query at its final step; the result holds until taken.
`default_nettype none
module segment_tree_sum_min_query #(
  parameter int MAX_LEAVES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire logic [2:0]         operation,
  input  wire logic [10:0]        position,
  input  wire logic signed [31:0] value,
  input  wire logic [10:0]        range_low,
  input  wire logic [10:0]        range_high,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic signed [47:0]      answer,
  output logic                    none_found,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [10:0]        cfg_data
);

  stsmq_pkg::cmd_t cmd;
  stsmq_pkg::sts_t sts;

  // The register takes a write in any cycle; a request already taken keeps
  // the positions and tree range that were clamped when it was captured.
  assign cfg_ready = 1'b1;

  stsmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  stsmq_dp #(
    .MAX_LEAVES (MAX_LEAVES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .operation  (operation),
    .position   (position),
    .value      (value),
    .range_low  (range_low),
    .range_high (range_high),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .answer     (answer),
    .none_found (none_found)
  );

endmodule
`default_nettype wire

>>> rtl/stsmq_ctrl.sv
// Controller state machine for the segment tree sum/min query block.
`default_nettype none
module stsmq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire stsmq_pkg::sts_t sts,
  output stsmq_pkg::cmd_t      cmd
);

  stsmq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stsmq_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != stsmq_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      stsmq_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_next = stsmq_pkg::ST_IDLE;
      end
      stsmq_pkg::ST_IDLE: begin
        if (req_valid) state_next = stsmq_pkg::ST_DISPATCH;
      end
      stsmq_pkg::ST_DISPATCH: begin
        unique case (sts.op) inside
          stsmq_pkg::OP_CLEAR: state_next = stsmq_pkg::ST_CLEAR;
          stsmq_pkg::OP_ADD, stsmq_pkg::OP_PMIN: state_next = stsmq_pkg::ST_DESC;
          stsmq_pkg::OP_RSUM, stsmq_pkg::OP_RMIN: begin
            state_next = sts.range_empty ? stsmq_pkg::ST_RET : stsmq_pkg::ST_VISIT;
          end
          default: state_next = stsmq_pkg::ST_IDLE;
        endcase
      end
      stsmq_pkg::ST_DESC: begin
        if (sts.leaf) state_next = stsmq_pkg::ST_LEAF;
      end
      stsmq_pkg::ST_LEAF: begin
        state_next = sts.at_root ? stsmq_pkg::ST_IDLE : stsmq_pkg::ST_UP_RD;
      end
      stsmq_pkg::ST_UP_RD: state_next = stsmq_pkg::ST_UP_MRG;
      stsmq_pkg::ST_UP_MRG: begin
        state_next = sts.parent_root ? stsmq_pkg::ST_IDLE : stsmq_pkg::ST_UP_RD;
      end
      stsmq_pkg::ST_VISIT: begin
        if (sts.covered) state_next = stsmq_pkg::ST_FETCH;
      end
      stsmq_pkg::ST_FETCH: state_next = stsmq_pkg::ST_RET;
      stsmq_pkg::ST_RET: begin
        if (sts.sp_zero) begin
          if (sts.out_free) state_next = stsmq_pkg::ST_IDLE;
        end else if (sts.turn_ok) begin
          state_next = stsmq_pkg::ST_VISIT;
        end
      end
      default: state_next = stsmq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      stsmq_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      stsmq_pkg::ST_IDLE: cmd.capture = req_valid;
      stsmq_pkg::ST_DISPATCH: begin
        if (sts.op == stsmq_pkg::OP_CLEAR) cmd.clr_start = 1'b1;
        if ((sts.op == stsmq_pkg::OP_RSUM || sts.op == stsmq_pkg::OP_RMIN) &&
            sts.range_empty) begin
          cmd.ret_empty = 1'b1;
        end
      end
      stsmq_pkg::ST_DESC: begin
        if (sts.leaf) cmd.rd_cur = 1'b1;
        else cmd.desc_step = 1'b1;
      end
      stsmq_pkg::ST_LEAF: cmd.leaf_wr = 1'b1;
      stsmq_pkg::ST_UP_RD: cmd.sib_rd = 1'b1;
      stsmq_pkg::ST_UP_MRG: cmd.merge_wr = 1'b1;
      stsmq_pkg::ST_VISIT: begin
        if (sts.covered) cmd.rd_cur = 1'b1;
        else if (sts.go_left) cmd.push_left = 1'b1;
        else cmd.push_right = 1'b1;
      end
      stsmq_pkg::ST_FETCH: cmd.ret_mem = 1'b1;
      stsmq_pkg::ST_RET: begin
        if (sts.sp_zero) cmd.out_load = sts.out_free;
        else if (sts.turn_ok) cmd.turn = 1'b1;
        else cmd.pop = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  // A result is only loaded into the output register when it can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free) else $error("result loaded over a held result");

  // Reset always starts the clearing pass.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> state == stsmq_pkg::ST_CLEAR) else $error("reset did not start clear");

  // A fully covered node is always fetched next.
  a_cover_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == stsmq_pkg::ST_VISIT && sts.covered) |=> state == stsmq_pkg::ST_FETCH)
    else $error("covered node not fetched");

endmodule
`default_nettype wire

>>> rtl/stsmq_dp.sv
// Datapath of the segment tree block: node stores, walk registers, stack, output register.
`default_nettype none
module stsmq_dp #(
  parameter int MAX_LEAVES = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire stsmq_pkg::cmd_t           cmd,
  output stsmq_pkg::sts_t                sts,
  input  wire logic                      cfg_valid,
  input  wire logic [10:0]               cfg_data,
  input  wire logic [2:0]                operation,
  input  wire logic [10:0]               position,
  input  wire logic signed [31:0]        value,
  input  wire logic [10:0]               range_low,
  input  wire logic [10:0]               range_high,
  output logic                           res_valid,
  input  wire logic                      res_stall,
  output logic signed [47:0]             answer,
  output logic                           none_found
);

  localparam int NODES = 2 * MAX_LEAVES;
  localparam int AW    = $clog2(NODES);
  localparam int NW    = $clog2(4 * MAX_LEAVES);
  localparam int PW    = ($clog2(MAX_LEAVES + 1) > 11) ? $clog2(MAX_LEAVES + 1) : 11;
  localparam int SD    = $clog2(MAX_LEAVES) + 1;
  localparam int SIW   = $clog2(SD);
  localparam int SPW   = $clog2(SD + 1);

  typedef struct packed {
    logic [NW-1:0]                   o;
    logic [PW-1:0]                   lo;
    logic [PW-1:0]                   hi;
    logic signed [stsmq_pkg::SUM_W-1:0] acc;
    logic                            right;
  } frame_t;

  // Configuration register.
  logic [10:0] leaf_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= 11'd1024;
    end else if (cfg_valid) begin
      leaf_count <= cfg_data;
    end
  end

  logic [PW-1:0] n_used;
  always_comb begin
    if (leaf_count == 11'd0) n_used = PW'(1);
    else if (PW'(leaf_count) > PW'(MAX_LEAVES)) n_used = PW'(MAX_LEAVES);
    else n_used = PW'(leaf_count);
  end

  function automatic logic [PW-1:0] clamp(input logic [10:0] p, input logic [PW-1:0] n);
    logic [PW-1:0] pe;
    pe = PW'(p);
    if (pe == '0) clamp = PW'(1);
    else if (pe > n) clamp = n;
    else clamp = pe;
  endfunction

  // Captured request.
  stsmq_pkg::op_t        op_q;
  logic [PW-1:0]         pos_q, ql_q, qr_q;
  logic signed [31:0]    val_q;
  logic [NW-1:0]         o_q;
  logic [PW-1:0]         lo_q, hi_q;
  logic signed [47:0]    hs_q, ret_q;
  logic signed [31:0]    hm_q;
  logic [SPW-1:0]        sp_q;
  logic [AW-1:0]         cnt_q;
  frame_t                stk [SD];

  logic [PW-1:0] mid;
  assign mid = PW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

  logic is_sum;
  assign is_sum = (op_q == stsmq_pkg::OP_RSUM);

  frame_t        top;
  logic [PW-1:0] top_mid;
  assign top     = stk[SIW'(sp_q - SPW'(1))];
  assign top_mid = PW'(({1'b0, top.lo} + {1'b0, top.hi}) >> 1);

  // Node stores.
  logic signed [47:0] sum_mem [NODES];
  logic signed [31:0] min_mem [NODES];
  logic signed [47:0] sum_rd;
  logic signed [31:0] min_rd;
  logic               rd_in;
  logic [NW-1:0]      rd_node;
  logic [NW-1:0]      p_node;
  logic               in_o, in_p;

  assign rd_node = cmd.sib_rd ? (o_q ^ NW'(1)) : o_q;
  assign p_node  = o_q >> 1;
  assign in_o    = (o_q < NW'(NODES));
  assign in_p    = (p_node < NW'(NODES));

  logic signed [47:0] rs, ls, ms, acc_new;
  logic signed [31:0] rm, lm, mm;

  assign rs = rd_in ? sum_rd : 48'sd0;
  assign rm = rd_in ? min_rd : stsmq_pkg::EMPTY_MIN32;
  assign ls = (op_q == stsmq_pkg::OP_ADD) ?
              stsmq_pkg::sat48(rs, {{16{val_q[31]}}, val_q}) : rs;
  assign lm = (op_q == stsmq_pkg::OP_PMIN && val_q < rm) ? val_q : rm;
  assign ms = stsmq_pkg::sat48(hs_q, rs);
  assign mm = (hm_q < rm) ? hm_q : rm;
  assign acc_new = is_sum ? stsmq_pkg::sat48(top.acc, ret_q) :
                   ((ret_q < top.acc) ? ret_q : top.acc);

  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [47:0] wsum;
  logic signed [31:0] wmin;

  always_comb begin
    we    = 1'b0;
    waddr = AW'(o_q);
    wsum  = ls;
    wmin  = lm;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = cnt_q;
      wsum  = 48'sd0;
      wmin  = stsmq_pkg::EMPTY_MIN32;
    end else if (cmd.leaf_wr) begin
      we = in_o;
    end else if (cmd.merge_wr) begin
      we    = in_p;
      waddr = AW'(p_node);
      wsum  = ms;
      wmin  = mm;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      sum_mem[waddr] <= wsum;
      min_mem[waddr] <= wmin;
    end
    sum_rd <= sum_mem[AW'(rd_node)];
    min_rd <= min_mem[AW'(rd_node)];
    rd_in  <= (rd_node < NW'(NODES));
  end

  // Clearing counter and stack pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_q <= '0;
      sp_q  <= '0;
    end else begin
      if (cmd.clr_start) cnt_q <= '0;
      else if (cmd.clr_step) cnt_q <= cnt_q + AW'(1);
      if (cmd.capture) sp_q <= '0;
      else if (cmd.push_left || cmd.push_right) sp_q <= sp_q + SPW'(1);
      else if (cmd.pop) sp_q <= sp_q - SPW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= stsmq_pkg::op_t'(operation);
      pos_q <= clamp(position, n_used);
      val_q <= value;
      ql_q  <= clamp(range_low, n_used);
      qr_q  <= clamp(range_high, n_used);
      o_q   <= NW'(1);
      lo_q  <= PW'(1);
      hi_q  <= n_used;
    end else if (cmd.desc_step) begin
      if (pos_q <= mid) begin
        o_q  <= NW'({o_q, 1'b0});
        hi_q <= mid;
      end else begin
        o_q  <= NW'({o_q, 1'b1});
        lo_q <= mid + PW'(1);
      end
    end else if (cmd.push_left) begin
      o_q  <= NW'({o_q, 1'b0});
      hi_q <= mid;
    end else if (cmd.push_right) begin
      o_q  <= NW'({o_q, 1'b1});
      lo_q <= mid + PW'(1);
    end else if (cmd.turn) begin
      o_q  <= NW'({top.o, 1'b1});
      lo_q <= top_mid + PW'(1);
      hi_q <= top.hi;
    end else if (cmd.merge_wr) begin
      o_q <= p_node;
    end

    if (cmd.leaf_wr) begin
      hs_q <= in_o ? ls : 48'sd0;
      hm_q <= in_o ? lm : stsmq_pkg::EMPTY_MIN32;
    end else if (cmd.merge_wr) begin
      hs_q <= in_p ? ms : 48'sd0;
      hm_q <= in_p ? mm : stsmq_pkg::EMPTY_MIN32;
    end

    if (cmd.ret_mem) begin
      ret_q <= is_sum ? rs : {{16{rm[31]}}, rm};
    end else if (cmd.ret_empty) begin
      ret_q <= is_sum ? 48'sd0 : stsmq_pkg::EMPTY_MIN48;
    end else if (cmd.pop) begin
      ret_q <= acc_new;
    end

    if (cmd.push_left || cmd.push_right) begin
      stk[SIW'(sp_q)] <= '{o: o_q, lo: lo_q, hi: hi_q,
                           acc: (is_sum ? 48'sd0 : stsmq_pkg::EMPTY_MIN48),
                           right: cmd.push_right};
    end else if (cmd.turn) begin
      stk[SIW'(sp_q - SPW'(1))] <= '{o: top.o, lo: top.lo, hi: top.hi,
                                    acc: acc_new, right: 1'b1};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      answer     <= ret_q;
      none_found <= !is_sum && (ret_q == stsmq_pkg::EMPTY_MIN48);
    end
  end

  always_comb begin
    sts.op          = op_q;
    sts.leaf        = (lo_q == hi_q);
    sts.at_root     = (o_q == NW'(1));
    sts.parent_root = (p_node == NW'(1));
    sts.covered     = (ql_q <= lo_q) && (hi_q <= qr_q);
    sts.go_left     = (ql_q <= mid);
    sts.sp_zero     = (sp_q == '0);
    sts.turn_ok     = !top.right && (top_mid < qr_q);
    sts.range_empty = (ql_q > qr_q);
    sts.clr_last    = (cnt_q == AW'(NODES - 1));
    sts.out_free    = !res_valid || !res_stall;
  end

  // The stack never grows beyond the tree height.
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp_q <= SPW'(SD)) else $error("query stack overflow");

  // A reported empty minimum always carries the empty marker.
  a_none_marker: assert property (@(posedge clk) disable iff (rst)
    (res_valid && none_found) |-> answer == stsmq_pkg::EMPTY_MIN48)
    else $error("none_found without empty marker");

endmodule
`default_nettype wire
